/* hw/rtl/hrtq_pkg.sv */
package hrtq_pkg;

    // Widest slot index and byte position carried between the front and back parts.
    localparam int SLOT_W = 6;
    localparam int POS_W  = 7;

    // Request codes of an input item.
    typedef enum logic [2:0] {
        REQ_SET  = 3'd0,
        REQ_BYTE = 3'd1,
        REQ_GET  = 3'd2,
        REQ_SEND = 3'd3,
        REQ_DONE = 3'd4
    } t_req;

    // Status codes of a result item.
    typedef enum logic [2:0] {
        ST_QUEUED   = 3'd0,
        ST_FULL     = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_ACCEPTED = 3'd3,
        ST_REFUSED  = 3'd4,
        ST_NOTHING  = 3'd5
    } t_status;

    // Transfer kinds of an issued transfer.
    localparam logic [1:0] TK_INT      = 2'd0;
    localparam logic [1:0] TK_CTRL_SET = 2'd1;
    localparam logic [1:0] TK_CTRL_GET = 2'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] device_address;
        logic [7:0] interface_number;
        logic       use_interrupt;
        logic [7:0] rpt_id;
        logic [1:0] report_kind;
        logic [7:0] length;
        logic [7:0] payload_byte;
        logic       send_accepted;
        logic       flush;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] transfer_kind;
        logic [7:0] out_device_address;
        logic [7:0] out_interface;
        logic [7:0] out_report_id;
        logic [1:0] out_report_kind;
        logic [7:0] transfer_length;
        logic [7:0] data_byte;
        logic       last;
    } t_out_item;

    // Stored descriptor of one queued transfer.
    typedef struct packed {
        logic [7:0] dev;
        logic [7:0] itf;
        logic       use_int;
        logic [7:0] rid;
        logic [1:0] kind;
        logic [7:0] len;
        logic       is_get;
    } t_header;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        t_header           hdr;
    } t_hdr_wr;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [7:0]        data;
    } t_pay_wr;

    // Work handed from the front part to the back part.
    typedef struct packed {
        logic              is_stream;
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_EMIT = 2'd2
    } t_back_state;

endpackage

/* hw/rtl/hrtq_front.sv */
module hrtq_front #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int REPORT_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hrtq_pkg::t_in_item  i_item,
    input  logic                i_fifo_full,
    input  logic                i_back_idle,
    output logic                o_push,
    output hrtq_pkg::t_cmd      o_cmd,
    output hrtq_pkg::t_hdr_wr   o_hdr_wr,
    output hrtq_pkg::t_pay_wr   o_pay_wr
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(REPORT_BYTES + 1);
    localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);

    logic [QW-1:0] r_head, n_head;
    logic [QW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_idle, n_idle;
    logic          r_fill_act, n_fill_act;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_fill_len, n_fill_len;

    logic       req_makes_result;
    logic       req_writes;
    logic       accept;
    logic       pre;
    logic [8:0] total;

    // An item that writes the stores waits until the back part has nothing to read.
    always_comb begin
        req_makes_result = (i_item.req_type == hrtq_pkg::REQ_SET) ||
                           (i_item.req_type == hrtq_pkg::REQ_GET) ||
                           (i_item.req_type == hrtq_pkg::REQ_SEND);
        req_writes       = (i_item.req_type == hrtq_pkg::REQ_SET) ||
                           (i_item.req_type == hrtq_pkg::REQ_BYTE) ||
                           (i_item.req_type == hrtq_pkg::REQ_GET);
        o_ready = !(req_makes_result && i_fifo_full) && !(req_writes && !i_back_idle);
        accept  = i_valid && o_ready;
    end

    // Classify the item and update the queue pointers.
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_cnt      = r_cnt;
        n_idle     = r_idle;
        n_fill_act = r_fill_act;
        n_pos      = r_pos;
        n_fill_len = r_fill_len;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_hdr_wr   = '0;
        o_pay_wr   = '0;
        pre        = (i_item.req_type == hrtq_pkg::REQ_SET) && (i_item.rpt_id != 8'd0);
        total      = {1'b0, i_item.length} + {8'd0, pre};

        if (accept) begin
            if (i_item.flush) begin
                n_head     = '0;
                n_tail     = '0;
                n_cnt      = '0;
                n_idle     = 1'b1;
                n_fill_act = 1'b0;
                n_pos      = '0;
            end

            if (i_item.req_type == hrtq_pkg::REQ_BYTE) begin
                // Payload byte goes into the entry being filled, if any.
                if (n_fill_act) begin
                    o_pay_wr.en   = 1'b1;
                    o_pay_wr.slot = hrtq_pkg::SLOT_W'(n_tail);
                    o_pay_wr.pos  = hrtq_pkg::POS_W'(n_pos);
                    o_pay_wr.data = i_item.payload_byte;
                    n_pos         = n_pos + PW'(1);
                    if (n_pos >= n_fill_len) begin
                        n_tail     = (n_tail == LAST_SLOT) ? '0 : n_tail + QW'(1);
                        n_cnt      = n_cnt + CW'(1);
                        n_fill_act = 1'b0;
                        n_pos      = '0;
                    end
                end
            end else begin
                // Any other item abandons an unfinished fill.
                n_fill_act = 1'b0;
                n_pos      = '0;
                case (i_item.req_type)
                    hrtq_pkg::REQ_SET, hrtq_pkg::REQ_GET: begin
                        o_push = 1'b1;
                        if (n_cnt >= CW'(QUEUE_DEPTH)) begin
                            o_cmd.status = hrtq_pkg::ST_FULL;
                        end else if ((i_item.req_type == hrtq_pkg::REQ_SET) &&
                                     (total > 9'(REPORT_BYTES))) begin
                            o_cmd.status = hrtq_pkg::ST_TOO_LONG;
                        end else begin
                            o_cmd.status        = hrtq_pkg::ST_QUEUED;
                            o_hdr_wr.en         = 1'b1;
                            o_hdr_wr.slot       = hrtq_pkg::SLOT_W'(n_tail);
                            o_hdr_wr.hdr.dev    = i_item.device_address;
                            o_hdr_wr.hdr.itf    = i_item.interface_number;
                            o_hdr_wr.hdr.use_int = i_item.use_interrupt;
                            o_hdr_wr.hdr.rid    = i_item.rpt_id;
                            o_hdr_wr.hdr.kind   = i_item.report_kind;
                            o_hdr_wr.hdr.len    = total[7:0];
                            o_hdr_wr.hdr.is_get = (i_item.req_type == hrtq_pkg::REQ_GET);
                            if (pre) begin
                                o_pay_wr.en   = 1'b1;
                                o_pay_wr.slot = hrtq_pkg::SLOT_W'(n_tail);
                                o_pay_wr.pos  = '0;
                                o_pay_wr.data = i_item.rpt_id;
                            end
                            if ((i_item.req_type == hrtq_pkg::REQ_GET) ||
                                (total == {8'd0, pre})) begin
                                n_tail = (n_tail == LAST_SLOT) ? '0 : n_tail + QW'(1);
                                n_cnt  = n_cnt + CW'(1);
                            end else begin
                                n_fill_act = 1'b1;
                                n_pos      = PW'(pre);
                                n_fill_len = PW'(total);
                            end
                        end
                    end
                    hrtq_pkg::REQ_SEND: begin
                        o_push = 1'b1;
                        if ((n_cnt == '0) || !n_idle) begin
                            o_cmd.status = hrtq_pkg::ST_NOTHING;
                        end else begin
                            o_cmd.is_stream = 1'b1;
                            o_cmd.slot      = hrtq_pkg::SLOT_W'(n_head);
                            o_cmd.status    = i_item.send_accepted ?
                                              hrtq_pkg::ST_ACCEPTED : hrtq_pkg::ST_REFUSED;
                            if (i_item.send_accepted) begin
                                n_idle = 1'b0;
                                n_head = (n_head == LAST_SLOT) ? '0 : n_head + QW'(1);
                                n_cnt  = n_cnt - CW'(1);
                            end
                        end
                    end
                    hrtq_pkg::REQ_DONE: begin
                        n_idle = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Queue control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_cnt      <= '0;
            r_idle     <= 1'b1;
            r_fill_act <= 1'b0;
            r_pos      <= '0;
            r_fill_len <= '0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_cnt      <= n_cnt;
            r_idle     <= n_idle;
            r_fill_act <= n_fill_act;
            r_pos      <= n_pos;
            r_fill_len <= n_fill_len;
        end
    end

endmodule

/* hw/rtl/hrtq_cmd_fifo.sv */
module hrtq_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hrtq_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output hrtq_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);

    hrtq_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    // Two-entry command queue between the front and back parts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/hrtq_back.sv */
module hrtq_back #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int REPORT_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hrtq_pkg::t_hdr_wr   i_hdr_wr,
    input  hrtq_pkg::t_pay_wr   i_pay_wr,
    input  hrtq_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_pop,
    output logic                o_idle,
    output logic                o_valid,
    input  logic                i_ready,
    output hrtq_pkg::t_out_item o_item
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int KW = $clog2(REPORT_BYTES + 1);
    localparam int AW = $clog2(QUEUE_DEPTH * REPORT_BYTES);
    localparam logic [AW-1:0] ROW_BYTES = AW'(REPORT_BYTES);

    hrtq_pkg::t_header r_hdr_mem [QUEUE_DEPTH];
    logic [7:0]        r_pay_mem [QUEUE_DEPTH * REPORT_BYTES];

    hrtq_pkg::t_back_state r_state, n_state;
    hrtq_pkg::t_header     r_hdr;
    logic [7:0]            r_pay_q;
    logic [QW-1:0]         r_slot, n_slot;
    logic [2:0]            r_st, n_st;
    logic [KW-1:0]         r_k, n_k;
    hrtq_pkg::t_out_item   r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic          hdr_rd_en;
    logic          pay_rd_en;
    logic          out_free;
    logic          has_data;
    logic [KW-1:0] n_bytes;
    logic [1:0]    tk;
    logic [AW-1:0] pay_rd_addr;
    logic [AW-1:0] pay_wr_addr;

    // Descriptor and payload stores; reads are registered.
    assign pay_wr_addr = AW'(i_pay_wr.slot[QW-1:0]) * ROW_BYTES + AW'(i_pay_wr.pos);
    assign pay_rd_addr = AW'(r_slot) * ROW_BYTES + AW'(r_k);

    always_ff @(posedge i_clk) begin
        if (i_hdr_wr.en) begin
            r_hdr_mem[i_hdr_wr.slot[QW-1:0]] <= i_hdr_wr.hdr;
        end
        if (hdr_rd_en) begin
            r_hdr <= r_hdr_mem[i_cmd.slot[QW-1:0]];
        end
        if (i_pay_wr.en) begin
            r_pay_mem[pay_wr_addr] <= i_pay_wr.data;
        end
        if (pay_rd_en) begin
            r_pay_q <= r_pay_mem[pay_rd_addr];
        end
    end

    // Shape of the transfer held in the descriptor register.
    always_comb begin
        has_data = !r_hdr.is_get && (r_hdr.len != 8'd0);
        if (!has_data) begin
            n_bytes = KW'(1);
        end else if (r_hdr.len > 8'(REPORT_BYTES)) begin
            n_bytes = KW'(REPORT_BYTES);
        end else begin
            n_bytes = KW'(r_hdr.len);
        end
        if (r_hdr.is_get) begin
            tk = hrtq_pkg::TK_CTRL_GET;
        end else if (r_hdr.use_int) begin
            tk = hrtq_pkg::TK_INT;
        end else begin
            tk = hrtq_pkg::TK_CTRL_SET;
        end
    end

    // Sequencer: take a command, then give its single status result or stream one result per stored byte.
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_st        = r_st;
        n_k         = r_k;
        n_out       = r_out;
        out_free    = !r_out_valid || i_ready;
        n_out_valid = r_out_valid && !i_ready;
        hdr_rd_en   = 1'b0;
        pay_rd_en   = 1'b0;
        o_pop       = 1'b0;

        case (r_state)
            hrtq_pkg::BK_IDLE: begin
                if (!i_cmd_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_stream) begin
                        hdr_rd_en = 1'b1;
                        n_slot    = i_cmd.slot[QW-1:0];
                        n_st      = i_cmd.status;
                        n_k       = '0;
                        n_state   = hrtq_pkg::BK_READ;
                    end else begin
                        n_out        = '0;
                        n_out.status = i_cmd.status;
                        n_out.last   = 1'b1;
                        n_out_valid  = 1'b1;
                    end
                end
            end
            hrtq_pkg::BK_READ: begin
                pay_rd_en = 1'b1;
                n_state   = hrtq_pkg::BK_EMIT;
            end
            hrtq_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_out.status             = r_st;
                    n_out.transfer_kind      = tk;
                    n_out.out_device_address = r_hdr.dev;
                    n_out.out_interface      = r_hdr.itf;
                    n_out.out_report_id      = r_hdr.rid;
                    n_out.out_report_kind    = r_hdr.kind;
                    n_out.transfer_length    = r_hdr.len;
                    n_out.data_byte          = has_data ? r_pay_q : 8'd0;
                    n_out.last               = (r_k == n_bytes - KW'(1));
                    n_out_valid              = 1'b1;
                    if (r_k == n_bytes - KW'(1)) begin
                        n_state = hrtq_pkg::BK_IDLE;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = hrtq_pkg::BK_READ;
                    end
                end
            end
            default: begin
                n_state = hrtq_pkg::BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrtq_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and the output register.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_st   <= n_st;
        r_k    <= n_k;
        r_out  <= n_out;
    end

    assign o_idle  = (r_state == hrtq_pkg::BK_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

/* hw/rtl/hid_report_transfer_queue.sv */
// An enqueue or an empty send gives its result through the command queue and the output register.
// An issued send reads the payload store in BK_READ and emits in BK_EMIT, one result per
// stored byte; a stalled receiver holds the stream, and the next command waits until it ends.
// Other items give no result; store writes wait while the back part still reads a transfer.
// Reset is synchronous and active low; it empties the queue and marks it idle.
// The descriptor and payload stores are not cleared.
module hid_report_transfer_queue #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int REPORT_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hrtq_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output hrtq_pkg::t_out_item o_item
);

    logic              push;
    logic              pop;
    logic              fifo_empty;
    logic              fifo_full;
    logic              back_idle;
    hrtq_pkg::t_cmd    cmd_in;
    hrtq_pkg::t_cmd    cmd_out;
    hrtq_pkg::t_hdr_wr hdr_wr;
    hrtq_pkg::t_pay_wr pay_wr;

    // The back part has nothing to read once its queue is empty and it is idle.
    logic back_fsm_idle;
    assign back_idle = fifo_empty && back_fsm_idle;

    hrtq_front #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .REPORT_BYTES (REPORT_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .i_fifo_full (fifo_full),
        .i_back_idle (back_idle),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .o_hdr_wr    (hdr_wr),
        .o_pay_wr    (pay_wr)
    );

    hrtq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    hrtq_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .REPORT_BYTES (REPORT_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr_wr    (hdr_wr),
        .i_pay_wr    (pay_wr),
        .i_cmd       (cmd_out),
        .i_cmd_empty (fifo_empty),
        .o_pop       (pop),
        .o_idle      (back_fsm_idle),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

/* dv/hid_report_transfer_queue_checker.sv */
module hid_report_transfer_queue_checker #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int REPORT_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  hrtq_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  hrtq_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int PRINT_LIMIT = 40;

    // Shadow copy of the transfer ring and its fill and link state.
    hrtq_pkg::t_header slot_hdr[QUEUE_DEPTH];
    logic [7:0]        slot_bytes[QUEUE_DEPTH*REPORT_BYTES];
    int                head_slot;
    int                tail_slot;
    int                queued;
    bit                link_idle;
    int                fill_pos;
    bit                filling;

    // Result items predicted but not yet seen on the output.
    hrtq_pkg::t_out_item pending_results[$];
    int                  result_index;

    task automatic report_mismatch(string msg);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("ERROR t=%0t: %s", $realtime, msg);
        end
        o_fail_count++;
    endtask

    function automatic void clear_ring();
        head_slot = 0;
        tail_slot = 0;
        queued    = 0;
        link_idle = 1'b1;
        filling   = 1'b0;
        fill_pos  = 0;
    endfunction

    function automatic void commit_tail();
        tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
        queued++;
        filling  = 1'b0;
        fill_pos = 0;
    endfunction

    function automatic void push_status(hrtq_pkg::t_status st);
        hrtq_pkg::t_out_item r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow ring by one accepted item and queue its result items.
    function automatic void apply_request(hrtq_pkg::t_in_item it);
        hrtq_pkg::t_header   h;
        int                  total;
        bit                  prefix;
        int                  n;
        hrtq_pkg::t_out_item r;
        if (it.flush) begin
            clear_ring();
        end

        // A payload byte only lands while a set transfer is being filled.
        if (it.req_type == hrtq_pkg::REQ_BYTE) begin
            if (filling) begin
                if (fill_pos < REPORT_BYTES) begin
                    slot_bytes[tail_slot*REPORT_BYTES + fill_pos] = it.payload_byte;
                end
                fill_pos++;
                if (fill_pos >= int'(slot_hdr[tail_slot].len)) begin
                    commit_tail();
                end
            end
            return;
        end

        // Any other item abandons a fill that is still open.
        filling  = 1'b0;
        fill_pos = 0;

        if (it.req_type == hrtq_pkg::REQ_SET || it.req_type == hrtq_pkg::REQ_GET) begin
            prefix = (it.req_type == hrtq_pkg::REQ_SET) && (it.rpt_id != 8'd0);
            total  = int'(it.length) + int'(prefix);
            // The full check wins over the length check.
            if (queued >= QUEUE_DEPTH) begin
                push_status(hrtq_pkg::ST_FULL);
            end else if (it.req_type == hrtq_pkg::REQ_SET && total > REPORT_BYTES) begin
                push_status(hrtq_pkg::ST_TOO_LONG);
            end else begin
                h.dev     = it.device_address;
                h.itf     = it.interface_number;
                h.use_int = it.use_interrupt;
                h.rid     = it.rpt_id;
                h.kind    = it.report_kind;
                h.len     = 8'(total);
                h.is_get  = (it.req_type == hrtq_pkg::REQ_GET);
                slot_hdr[tail_slot] = h;
                if (it.req_type == hrtq_pkg::REQ_GET) begin
                    commit_tail();
                end else begin
                    if (prefix) begin
                        slot_bytes[tail_slot*REPORT_BYTES] = it.rpt_id;
                    end
                    fill_pos = int'(prefix);
                    if (total == int'(prefix)) begin
                        commit_tail();
                    end else begin
                        filling = 1'b1;
                    end
                end
                push_status(hrtq_pkg::ST_QUEUED);
            end
        end else if (it.req_type == hrtq_pkg::REQ_SEND) begin
            if (queued == 0 || !link_idle) begin
                push_status(hrtq_pkg::ST_NOTHING);
                return;
            end
            h = slot_hdr[head_slot];
            n = 1;
            if (!h.is_get && h.len > 8'd0) begin
                n = (int'(h.len) > REPORT_BYTES) ? REPORT_BYTES : int'(h.len);
            end
            // One result item per stored byte; a get or an empty set gives one.
            for (int k = 0; k < n; k++) begin
                r.status             = it.send_accepted ? hrtq_pkg::ST_ACCEPTED :
                                                          hrtq_pkg::ST_REFUSED;
                r.transfer_kind      = h.is_get ? hrtq_pkg::TK_CTRL_GET :
                                       (h.use_int ? hrtq_pkg::TK_INT : hrtq_pkg::TK_CTRL_SET);
                r.out_device_address = h.dev;
                r.out_interface      = h.itf;
                r.out_report_id      = h.rid;
                r.out_report_kind    = h.kind;
                r.transfer_length    = h.len;
                r.data_byte          = (!h.is_get && h.len > 8'd0) ?
                                       slot_bytes[head_slot*REPORT_BYTES + k] : 8'd0;
                r.last               = (k == n - 1);
                pending_results.push_back(r);
            end
            if (it.send_accepted) begin
                link_idle = 1'b0;
                head_slot = (head_slot + 1) % QUEUE_DEPTH;
                queued--;
            end
        end else if (it.req_type == hrtq_pkg::REQ_DONE) begin
            link_idle = 1'b1;
        end
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            report_mismatch($sformatf("result %0d field %s: expected %0d, got %0d",
                                      result_index, name, want, got));
        end
    endtask

    // Match one result item against the oldest prediction.
    task automatic check_result(hrtq_pkg::t_out_item got);
        hrtq_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                      result_index));
        end else begin
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("transfer_kind", want.transfer_kind, got.transfer_kind);
            compare_field("out_device_address", want.out_device_address,
                          got.out_device_address);
            compare_field("out_interface", want.out_interface, got.out_interface);
            compare_field("out_report_id", want.out_report_id, got.out_report_id);
            compare_field("out_report_kind", want.out_report_kind, got.out_report_kind);
            compare_field("transfer_length", want.transfer_length, got.transfer_length);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("last", want.last, got.last);
        end
        result_index++;
    endtask

    // Outputs are checked before the new input so a same-cycle item cannot match.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_ring();
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_item);
            end
            if (i_in_valid && i_in_ready) begin
                apply_request(i_in_item);
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

/* dv/hid_report_transfer_queue_tb.sv */
module hid_report_transfer_queue_tb;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 600000;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    hrtq_pkg::t_in_item  i_item  = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    hrtq_pkg::t_out_item o_item;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int cycles        = 0;
    bit hold_armed    = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;

    always #10 i_clk = ~i_clk;

    hid_report_transfer_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    hid_report_transfer_queue_checker result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus one long hold-off when it is armed.
    always @(posedge i_clk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // An item with every field random, apart from the request code and flush.
    function automatic hrtq_pkg::t_in_item random_fields(logic [2:0] req);
        logic [63:0]        raw;
        hrtq_pkg::t_in_item it;
        raw         = {$urandom, $urandom};
        it          = raw[$bits(hrtq_pkg::t_in_item)-1:0];
        it.req_type = req;
        it.flush    = 1'b0;
        return it;
    endfunction

    function automatic hrtq_pkg::t_in_item set_item(logic [7:0] rid, logic [7:0] len);
        hrtq_pkg::t_in_item it;
        it        = random_fields(hrtq_pkg::REQ_SET);
        it.rpt_id = rid;
        it.length = len;
        return it;
    endfunction

    function automatic hrtq_pkg::t_in_item send_item(bit accepted);
        hrtq_pkg::t_in_item it;
        it               = random_fields(hrtq_pkg::REQ_SEND);
        it.send_accepted = accepted;
        return it;
    endfunction

    function automatic hrtq_pkg::t_in_item byte_item(logic [7:0] value);
        hrtq_pkg::t_in_item it;
        it              = random_fields(hrtq_pkg::REQ_BYTE);
        it.payload_byte = value;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until it is taken.
    task automatic push_item(hrtq_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        items_sent++;
    endtask

    task automatic fill_set(logic [7:0] rid, logic [7:0] len, int nbytes);
        push_item(set_item(rid, len));
        repeat (nbytes) push_item(random_fields(hrtq_pkg::REQ_BYTE));
    endtask

    // Mostly complete set sequences, sends and completions, with some noise.
    task automatic run_random(int count);
        int                 stop_at;
        int                 pick;
        int                 len;
        int                 nbytes;
        logic [7:0]         rid;
        hrtq_pkg::t_in_item it;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            rid  = $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'd0;
            if (pick < 30) begin
                len    = $urandom_range(8);
                nbytes = len;
                // Now and then the fill is cut short and later abandoned.
                if ($urandom_range(9) == 0) begin
                    nbytes = $urandom_range(len);
                end
                fill_set(rid, 8'(len), nbytes);
            end else if (pick < 42) begin
                push_item(random_fields(hrtq_pkg::REQ_GET));
            end else if (pick < 72) begin
                push_item(send_item($urandom_range(3) != 0));
            end else if (pick < 88) begin
                push_item(random_fields(hrtq_pkg::REQ_DONE));
            end else if (pick < 91) begin
                push_item(set_item(rid, 8'($urandom_range(255, 65))));
            end else if (pick < 94) begin
                it       = random_fields(3'($urandom_range(4)));
                it.flush = 1'b1;
                push_item(it);
            end else if (pick < 97) begin
                push_item(random_fields(hrtq_pkg::REQ_BYTE));
            end else begin
                push_item(random_fields(3'($urandom_range(7, 5))));
            end
        end
    endtask

    // Directed opening: empty and busy sends, length limits, prefix, abandon, full.
    task automatic run_directed();
        hrtq_pkg::t_in_item it;
        push_item(send_item(1'b1));
        push_item(random_fields(hrtq_pkg::REQ_DONE));
        it                  = set_item(8'd0, 8'd0);
        it.device_address   = 8'd0;
        it.interface_number = 8'd0;
        it.use_interrupt    = 1'b1;
        it.report_kind      = 2'd0;
        push_item(it);
        push_item(send_item(1'b1));
        push_item(send_item(1'b1));
        push_item(random_fields(hrtq_pkg::REQ_DONE));
        push_item(set_item(8'hFF, 8'd64));
        push_item(set_item(8'd0, 8'd255));
        it                  = set_item(8'hFF, 8'd2);
        it.device_address   = 8'hFF;
        it.interface_number = 8'hFF;
        it.use_interrupt    = 1'b0;
        it.report_kind      = 2'd3;
        push_item(it);
        push_item(byte_item(8'h00));
        push_item(byte_item(8'hFF));
        push_item(set_item(8'h80, 8'd3));
        push_item(byte_item(8'h5A));
        it             = random_fields(hrtq_pkg::REQ_GET);
        it.length      = 8'd255;
        it.report_kind = 2'd3;
        push_item(it);
        push_item(byte_item(8'hC3));
        push_item(send_item(1'b0));
        push_item(send_item(1'b1));
        push_item(random_fields(hrtq_pkg::REQ_DONE));
        push_item(send_item(1'b1));
        push_item(random_fields(hrtq_pkg::REQ_DONE));
        // Fill the ring; a set that is both too long and too many reports full.
        repeat (8) push_item(random_fields(hrtq_pkg::REQ_GET));
        push_item(set_item(8'd0, 8'd255));
        it       = send_item(1'b1);
        it.flush = 1'b1;
        push_item(it);
        push_item(random_fields(3'd7));
    endtask

    // Long receiver hold-off while long transfers are queued and sent.
    task automatic run_pressure();
        hrtq_pkg::t_in_item it;
        it       = random_fields(hrtq_pkg::REQ_DONE);
        it.flush = 1'b1;
        push_item(it);
        hold_armed <= 1'b1;
        fill_set(8'd0, 8'd16, 16);
        fill_set(8'hA5, 8'd15, 15);
        repeat (2) begin
            push_item(send_item(1'b1));
            push_item(random_fields(hrtq_pkg::REQ_DONE));
        end
        repeat (3) begin
            push_item(random_fields(hrtq_pkg::REQ_GET));
            push_item(send_item(1'b1));
            push_item(random_fields(hrtq_pkg::REQ_DONE));
        end
    endtask

    // Watchdog on the total run length.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("hid_report_transfer_queue test failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 75;
        run_directed();
        run_random(12);

        send_idle_pct = 75;
        recv_idle_pct = 24;
        run_random(12);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_pressure();
        run_random(8);

        // Let every predicted result drain, then allow stragglers to show up.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("hid_report_transfer_queue test passed");
        end else begin
            $display("hid_report_transfer_queue test failed");
        end
        $finish;
    end

endmodule
